/* rtl/pll_divider_search_core_macros.svh */
// assertion helpers used by the checker file
`ifndef PLL_DIVIDER_SEARCH_CORE_MACROS_SVH
`define PLL_DIVIDER_SEARCH_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, quiet in reset
`define PDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, quiet in reset
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Constants and types of the PLL divider search core: reference clocks,
// per pre-divider quotient tables, search limits and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int unsigned LegRefHz = 14318180;
  localparam int unsigned ProRefHz = 14318000;

  localparam logic [29:0] PRO_VCO_MIN_HZ = 30'd300000000;

  localparam logic [8:0] LEG_FB_LAST = 9'd127;
  localparam logic [8:0] PRO_FB_LAST = 9'd298;
  localparam logic [2:0] LEG_R_LAST  = 3'd3;
  localparam logic [2:0] LEG_N_LAST  = 3'd7;
  localparam logic [2:0] POST_MAX    = 3'd7;

  localparam logic [19:0] BAND_LOW_KHZ  = 20'd30000;
  localparam logic [19:0] BAND_MID_KHZ  = 20'd45000;
  localparam logic [19:0] BAND_HIGH_KHZ = 20'd170000;

  // register map (word index)
  localparam logic REG_PLL_STYLE = 1'b0;

  // floor(ref / n) and ref mod n for n = 1..7, entry 0 unused
  localparam logic [23:0] LEG_QN [8] = '{
    24'd0, 24'(LegRefHz / 1), 24'(LegRefHz / 2), 24'(LegRefHz / 3),
    24'(LegRefHz / 4), 24'(LegRefHz / 5), 24'(LegRefHz / 6), 24'(LegRefHz / 7)};
  localparam logic [2:0] LEG_RN [8] = '{
    3'd0, 3'(LegRefHz % 1), 3'(LegRefHz % 2), 3'(LegRefHz % 3),
    3'(LegRefHz % 4), 3'(LegRefHz % 5), 3'(LegRefHz % 6), 3'(LegRefHz % 7)};
  localparam logic [23:0] PRO_QN [8] = '{
    24'd0, 24'(ProRefHz / 1), 24'(ProRefHz / 2), 24'(ProRefHz / 3),
    24'(ProRefHz / 4), 24'(ProRefHz / 5), 24'(ProRefHz / 6), 24'(ProRefHz / 7)};
  localparam logic [2:0] PRO_RN [8] = '{
    3'd0, 3'(ProRefHz % 1), 3'(ProRefHz % 2), 3'(ProRefHz % 3),
    3'(ProRefHz % 4), 3'(ProRefHz % 5), 3'(ProRefHz % 6), 3'(ProRefHz % 7)};

  typedef struct packed {
    logic load;  // set up a new (n, r) row at m = 1
    logic step;  // advance to m + 1
  } acc_ctrl_t;

endpackage

`default_nettype wire

/* rtl/pds_acc.sv */
// ----------------------------------------------------------------------------
// pds_acc
// Running quotient of ref * m / (n << r): keeps quotient and remainder and
// adds the per-row increment on each step, so no divider is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_acc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pds_pkg::acc_ctrl_t ctrl_i,
  input  wire logic              style_i,
  input  wire logic [2:0]        n_i,
  input  wire logic [2:0]        r_i,
  output logic [31:0]            q_o
);

  logic [31:0] q_q, q_d;
  logic [9:0]  rem_q, rem_d;
  logic [23:0] qd_q, qd_d;
  logic [9:0]  rd_q, rd_d;
  logic [9:0]  div_q, div_d;

  logic [23:0] qn;
  logic [2:0]  rn;
  logic [6:0]  low;
  logic [10:0] rem_sum;

  // split ref / (n << r) from ref / n: quotient shifts, low bits fold into remainder
  always_comb begin
    qn   = style_i ? pds_pkg::PRO_QN[n_i] : pds_pkg::LEG_QN[n_i];
    rn   = style_i ? pds_pkg::PRO_RN[n_i] : pds_pkg::LEG_RN[n_i];
    low  = qn[6:0] & 7'((8'd1 << r_i) - 8'd1);
    qd_d = qn >> r_i;
    rd_d = 10'(low) * 10'(n_i) + 10'(rn);
    div_d = 10'({7'd0, n_i} << r_i);
  end

  always_comb begin
    rem_sum = 11'(rem_q) + 11'(rd_q);
    q_d     = q_q;
    rem_d   = rem_q;
    if (ctrl_i.load) begin
      q_d   = 32'(qd_d);
      rem_d = rd_d;
    end else if (ctrl_i.step) begin
      if (rem_sum >= 11'(div_q)) begin
        rem_d = 10'(rem_sum - 11'(div_q));
        q_d   = q_q + 32'(qd_q) + 32'd1;
      end else begin
        rem_d = rem_sum[9:0];
        q_d   = q_q + 32'(qd_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q   <= '0;
      rem_q <= '0;
    end else begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      qd_q  <= qd_d;
      rd_q  <= rd_d;
      div_q <= div_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

/* rtl/pll_divider_search_core.sv */
// legacy style scans 27 rows of feedback values, then finishes
// pro style makes up to 8 post divider checks, then scans up to 6 rows, then
// finishes; a zero clock goes straight to finish
// throughput: one item at a time, ready again in the cycle its result appears
// one candidate per cycle while scanning a row, through the shared running-quotient accumulator
// reset is asynchronous, active low: style returns to legacy, sequencer to idle, no result held
// ----------------------------------------------------------------------------
// pll_divider_search_core
// Searches the PLL post, pre and feedback dividers that come closest to a
// requested pixel clock, in legacy or pro style.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_search_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [19:0] clock_khz
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [0] found, [3:1] post_div, [6:4] pre_div,
                                          // [15:7] fb_div, [16] tuning_bit
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_POST   = 5'b00010,
    ST_ROW    = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic        style_q;
  logic [29:0] target_q, target_d;
  logic [22:0] tol_q, tol_d;
  logic [29:0] tsh_q, tsh_d;
  logic [2:0]  r_q, r_d;
  logic [2:0]  n_q, n_d;
  logic [2:0]  nlast_q, nlast_d;
  logic [8:0]  m_q, m_d;
  logic        have_q, have_d;
  logic [31:0] best_e_q, best_e_d;
  logic [2:0]  br_q, br_d;
  logic [2:0]  bn_q, bn_d;
  logic [8:0]  bm_q, bm_d;
  logic        out_valid_q;
  logic [23:0] out_data_q;

  logic [19:0] khz;
  logic [31:0] q;
  logic [31:0] err;
  logic        eval_ok;
  logic [8:0]  m_last;
  logic        cfg_wr;
  pds_pkg::acc_ctrl_t acc_ctrl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == pds_pkg::REG_PLL_STYLE) begin
      style_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      pds_pkg::REG_PLL_STYLE: prdata = {31'd0, style_q};
      default:                prdata = '0;
    endcase
  end

  assign khz           = s_axis_tdata[19:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_last        = style_q ? pds_pkg::PRO_FB_LAST : pds_pkg::LEG_FB_LAST;

  pds_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .style_i (style_q),
    .n_i     (n_q),
    .r_i     (r_q),
    .q_o     (q)
  );

  assign err = (q > 32'(target_q)) ? (q - 32'(target_q)) : (32'(target_q) - q);

  // pro style skips m = 1 and needs 200 * err < target, i.e. err < 5 * clock_khz
  assign eval_ok = (!style_q || (m_q != 9'd1 && err < 32'(tol_q))) &&
                   (!have_q || err < best_e_q);

  always_comb begin
    state_d  = state_q;
    target_d = target_q;
    tol_d    = tol_q;
    tsh_d    = tsh_q;
    r_d      = r_q;
    n_d      = n_q;
    nlast_d  = nlast_q;
    m_d      = m_q;
    have_d   = have_q;
    best_e_d = best_e_q;
    br_d     = br_q;
    bn_d     = bn_q;
    bm_d     = bm_q;
    acc_ctrl = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          target_d = 30'(khz) * 30'd1000;
          tol_d    = 23'({khz, 2'b00}) + 23'(khz);
          tsh_d    = 30'(khz) * 30'd1000;
          have_d   = 1'b0;
          r_d      = '0;
          n_d      = 3'd2;
          if (!style_q) begin
            nlast_d = pds_pkg::LEG_N_LAST;
          end else if (khz < pds_pkg::BAND_LOW_KHZ) begin
            nlast_d = 3'd7;
          end else if (khz < pds_pkg::BAND_MID_KHZ) begin
            nlast_d = 3'd6;
          end else if (khz < pds_pkg::BAND_HIGH_KHZ) begin
            nlast_d = 3'd5;
          end else begin
            nlast_d = 3'd4;
          end
          if (khz == '0) begin
            state_d = ST_FINISH;
          end else if (style_q) begin
            state_d = ST_POST;
          end else begin
            state_d = ST_ROW;
          end
        end
      end
      ST_POST: begin
        // smallest post divider lifting the clock to the vco floor
        if (tsh_q >= pds_pkg::PRO_VCO_MIN_HZ) begin
          state_d = ST_ROW;
        end else if (r_q == pds_pkg::POST_MAX) begin
          state_d = ST_FINISH;
        end else begin
          r_d   = r_q + 3'd1;
          tsh_d = {tsh_q[28:0], 1'b0};
        end
      end
      ST_ROW: begin
        acc_ctrl.load = 1'b1;
        m_d           = 9'd1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        if (eval_ok) begin
          have_d   = 1'b1;
          best_e_d = err;
          br_d     = r_q;
          bn_d     = n_q;
          bm_d     = m_q;
        end
        if (m_q == m_last) begin
          if (n_q != nlast_q) begin
            n_d     = n_q + 3'd1;
            state_d = ST_ROW;
          end else if (!style_q && r_q != pds_pkg::LEG_R_LAST) begin
            r_d     = r_q + 3'd1;
            n_d     = 3'd1;
            state_d = ST_ROW;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          m_d           = m_q + 9'd1;
          acc_ctrl.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      have_q  <= have_d;
      if (state_q == ST_FINISH && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    tol_q    <= tol_d;
    tsh_q    <= tsh_d;
    r_q      <= r_d;
    n_q      <= n_d;
    nlast_q  <= nlast_d;
    m_q      <= m_d;
    best_e_q <= best_e_d;
    br_q     <= br_d;
    bn_q     <= bn_d;
    bm_q     <= bm_d;
    if (state_q == ST_FINISH && (!out_valid_q || m_axis_tready)) begin
      if (have_q) begin
        out_data_q <= {7'd0, style_q, bm_q, bn_q, br_q, 1'b1};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/pds_checker.sv */
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the PLL divider search core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pll_divider_search_core_macros.svh"

module pds_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // a stalled result transaction keeps its payload
  `PDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // not found means every field is zero
  `PDS_ASSERT_NOW(a_zero_fields, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[23:1] == 23'd0, "fields set without a result")

  // a found result always has a non-zero pre and feedback divider within range
  `PDS_ASSERT_NOW(a_found_dividers, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[6:4] != 3'd0 && m_axis_tdata[15:7] != 9'd0 && m_axis_tdata[15:7] <= 9'd298, "bad divider in found result")

  // a request taken means the search runs, so the next cycle is not ready
  `PDS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accepting a request")

endmodule

bind pll_divider_search_core pds_checker u_pds_checker (.*);

`default_nettype wire
